### design/hdpr_pkg.sv
package hdpr_pkg;

  localparam int TABLE_DEPTH  = 65536;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int SIZE_W       = IDX_W + 1;
  localparam int KEY_W        = 64;
  localparam int KIND_W       = 2;
  localparam int DEPTH_W      = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(KEY_W + 1);

  localparam logic [SIZE_W-1:0] SIZE_FULL  = SIZE_W'(TABLE_DEPTH);
  localparam logic [KIND_W-1:0] KIND_PV    = KIND_W'(1);
  localparam logic [KEY_W-1:0]  KEY_EMPTY  = '0;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_STORE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [KIND_W-1:0]       kind;
    logic [DEPTH_W-1:0]      depth;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_t;

endpackage

### design/hdpr_if.sv
interface hdpr_req_if;
  import hdpr_pkg::*;

  logic                    valid;
  logic                    ready;
  op_t                     op;
  logic [KEY_W-1:0]        key;
  logic [KIND_W-1:0]       node_kind;
  logic [DEPTH_W-1:0]      search_depth;
  logic [PAYLOAD_BITS-1:0] entry_payload;

  modport source (output valid, op, key, node_kind, search_depth, entry_payload,
                  input ready);
  modport sink (input valid, op, key, node_kind, search_depth, entry_payload,
                output ready);
endinterface

interface hdpr_rsp_if;
  import hdpr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic                    collision;
  logic [KEY_W-1:0]        found_key;
  logic [KIND_W-1:0]       found_node_kind;
  logic [DEPTH_W-1:0]      found_depth;
  logic [PAYLOAD_BITS-1:0] found_payload;
  logic                    written;

  modport source (output valid, hit, collision, found_key, found_node_kind,
                  found_depth, found_payload, written, input ready);
  modport sink (input valid, hit, collision, found_key, found_node_kind,
                found_depth, found_payload, written, output ready);
endinterface

interface hdpr_cfg_if;
  import hdpr_pkg::*;

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink (input valid, entries_in_use, output ready);
endinterface

### design/hdpr_rem_unit.sv
module hdpr_rem_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hdpr_pkg::KEY_W-1:0]   dividend,
  input  logic [hdpr_pkg::SIZE_W-1:0]  divisor,
  output logic                         done,
  output logic [hdpr_pkg::IDX_W-1:0]   remainder
);
  import hdpr_pkg::*;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  logic [KEY_W-1:0]  shift_q;
  logic [SIZE_W-1:0] div_q;
  logic [SIZE_W-1:0] rem_q;
  logic [SIZE_W-1:0] rem_next;
  logic [CNT_W-1:0]  cnt;
  logic [SIZE_W:0]   trial;

  always_comb begin
    trial = {rem_q, shift_q[KEY_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_next = SIZE_W'(trial - {1'b0, div_q});
    end else begin
      rem_next = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(KEY_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_q <= dividend;
      div_q   <= divisor;
      rem_q   <= '0;
    end else if (cnt != '0) begin
      shift_q <= {shift_q[KEY_W-2:0], 1'b0};
      rem_q   <= rem_next;
    end
  end

  // The remainder is below the divisor, which never exceeds the table depth.
  assign done      = (cnt == '0);
  assign remainder = rem_q[IDX_W-1:0];

endmodule

### design/hash_table_depth_preferred_replace_unit.sv
// A request word goes through the bit-serial key remainder, a memory read and a decide step
// into the output register before the response word is valid.
// A new word is accepted only once the last one has finished its remainder loop and the
// read-modify-write of the slot memory, which waits while an earlier response is not taken.
// Reset: synchronous; afterwards a clearing pass writes all 65536 slots, one per cycle, during
// which no request is accepted. The size register returns to 65536.
module hash_table_depth_preferred_replace_unit (
  input  logic       clk,
  input  logic       rst,
  hdpr_req_if.sink   req,
  hdpr_rsp_if.source rsp,
  hdpr_cfg_if.sink   cfg
);
  import hdpr_pkg::*;

  state_t state;
  state_t state_next;

  // Configuration register. The divisor is captured when a word starts, so a write
  // only reaches the words that follow it.
  logic [SIZE_W-1:0] entries_in_use;
  logic [SIZE_W-1:0] eff_size;

  // The request word, held for the whole operation.
  op_t                     op_q;
  logic [KEY_W-1:0]        key_q;
  logic [KIND_W-1:0]       kind_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [IDX_W-1:0]        idx_q;

  logic [IDX_W-1:0] clr_addr;

  // Slot memory: one write port and one registered read port.
  slot_t            mem [TABLE_DEPTH];
  slot_t            rd_data;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;

  logic             rem_start;
  logic             rem_done;
  logic [IDX_W-1:0] rem_index;

  logic             accept;
  logic             out_free;
  logic             finish;

  // Decision on the slot read back from memory.
  logic hit_c;
  logic coll_c;
  logic store_ok;

  // Output register; while a response waits, the next word is taken in but cannot finish.
  logic                    out_valid;
  logic                    out_hit;
  logic                    out_coll;
  slot_t                   out_slot;
  logic                    out_written;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign finish   = (state == ST_READ) && out_free;

  // A size of zero or beyond the table falls back to the whole table.
  always_comb begin
    if (entries_in_use == '0 || entries_in_use > SIZE_FULL) begin
      eff_size = SIZE_FULL;
    end else begin
      eff_size = entries_in_use;
    end
  end

  hdpr_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (req.key),
    .divisor   (eff_size),
    .done      (rem_done),
    .remainder (rem_index)
  );

  // An empty slot always takes the store. An occupied principal-variation slot is kept
  // against an entry that is not one; otherwise only a strictly deeper entry replaces it.
  always_comb begin
    hit_c    = 1'b0;
    coll_c   = 1'b0;
    store_ok = 1'b0;
    unique case (op_q)
      OP_LOOKUP: begin
        hit_c  = (rd_data.key == key_q);
        coll_c = (rd_data.key != key_q) && (rd_data.key != KEY_EMPTY);
      end
      OP_STORE: begin
        if (rd_data.key == KEY_EMPTY) begin
          store_ok = 1'b1;
        end else if (rd_data.kind == KIND_PV && kind_q != KIND_PV) begin
          store_ok = 1'b0;
        end else begin
          store_ok = (depth_q > rd_data.depth);
        end
      end
      default: begin
        store_ok = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    rem_start = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = '{key: key_q, kind: kind_q, depth: depth_q, payload: payload_q};
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        rem_start = req.valid;
      end
      ST_DIVIDE: begin
        rd_en = rem_done;
      end
      ST_READ: begin
        wr_en = out_free && store_ok;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= SIZE_FULL;
    end else if (cfg.valid && cfg.ready) begin
      entries_in_use <= cfg.entries_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= req.op;
      key_q     <= req.key;
      kind_q    <= req.node_kind;
      depth_q   <= req.search_depth;
      payload_q <= req.entry_payload;
    end
    if (rd_en) begin
      idx_q <= rem_index;
    end
  end

  // The next read of any slot comes a full remainder pass after the last write,
  // so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rem_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_hit     <= hit_c;
      out_coll    <= coll_c;
      out_slot    <= rd_data;
      out_written <= store_ok;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.hit             = out_hit;
  assign rsp.collision       = out_coll;
  assign rsp.found_key       = out_slot.key;
  assign rsp.found_node_kind = out_slot.kind;
  assign rsp.found_depth     = out_slot.depth;
  assign rsp.found_payload   = out_slot.payload;
  assign rsp.written         = out_written;

endmodule
